@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assertion that is off while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ rtl/c3dc_pkg.sv @@
// ----------------------------------------------------------------------------
// c3dc_pkg
// types and constants of the 3x3 convolution block
// ----------------------------------------------------------------------------
package c3dc_pkg;

  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int COEF_W    = 24;
  localparam int DIVR_W    = 8;
  localparam int SUM_W     = 20;
  localparam int QUO_W     = 19;
  localparam int REM_W     = 8;
  localparam int TAPS      = 9;
  localparam int TAP_W     = 4;
  localparam int CNT_W     = 5;
  localparam int PLANES    = 3;
  localparam int MIN_SIZE  = 3;
  localparam int CLAMP_MAX = 255;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVR   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_MAC,
    S_PREP,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             update;
    logic             mac_clr;
    logic             mac_en;
    logic [TAP_W-1:0] tap;
    logic             div_init;
    logic             div_en;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/conv3x3_divide_clamp.sv @@
// border pixels give no output; a new pixel is taken only in idle, once the last one is done
// a border pixel passes idle and update; an interior pixel also passes mac, prep, div and load
// interior pixels run the 9-tap multiply-accumulate and the 19-step restoring divider
// a result left waiting on out_tready stalls the next interior pixel in the load step
// reset: synchronous active low, clears counters and output valid, restores config defaults
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp
// streaming 3x3 rgb convolution with signed divide and clamp to 0..255
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp
  import c3dc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [RGB_W-1:0]     in_tdata,   // red_in, green_in, blue_in
  input  logic                 in_tuser,   // frame_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // out_col, out_row, red_out, green_out, blue_out
  output logic                 out_tlast,
  output logic                 out_tuser   // divide_error
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  c3dc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c3dc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_frame_start (in_tuser),
    .in_pix         (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser)
  );

endmodule

@@ rtl/c3dc_ram.sv @@
// ----------------------------------------------------------------------------
// c3dc_ram
// simple dual port ram with registered read
// ----------------------------------------------------------------------------
module c3dc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/c3dc_ctrl.sv @@
// ----------------------------------------------------------------------------
// c3dc_ctrl
// sequencer: capture, line update, tap accumulation, divide, output load
// ----------------------------------------------------------------------------
module c3dc_ctrl
  import c3dc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = sts.produce ? S_MAC : S_IDLE;
      S_MAC:    if (cnt_r == CNT_W'(TAPS - 1)) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_DIV;
      S_DIV:    if (cnt_r == CNT_W'(QUO_W - 1)) state_nxt = S_LOAD;
      S_LOAD:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_nxt != state_r) begin
      cnt_nxt = '0;
    end else if (state_r == S_MAC || state_r == S_DIV) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.tap   = cnt_r[TAP_W-1:0];
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_UPDATE: begin
        cmd.update  = 1'b1;
        cmd.mac_clr = 1'b1;
      end
      S_MAC:    cmd.mac_en = 1'b1;
      S_PREP:   cmd.div_init = 1'b1;
      S_DIV:    cmd.div_en = 1'b1;
      S_LOAD:   cmd.out_load = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ rtl/c3dc_datapath.sv @@
// ----------------------------------------------------------------------------
// c3dc_datapath
// config registers, position counters, line stores, window, mac and divide
// ----------------------------------------------------------------------------
module c3dc_datapath
  import c3dc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_frame_start,
  input  logic [RGB_W-1:0]     in_pix,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int EH  = $clog2(MAX_HEIGHT + 1);
  localparam int EWX = (EW > SIZE_W) ? EW : SIZE_W;
  localparam int EHX = (EH > SIZE_W) ? EH : SIZE_W;
  localparam int PCW = (CW > POS_W) ? CW : POS_W;
  localparam int PRW = (RW > POS_W) ? RW : POS_W;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [COEF_W-1:0] coef0_r, coef1_r, coef2_r;
  logic [DIVR_W-1:0] divr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1024);
      height_r <= SIZE_W'(1024);
      coef0_r  <= '0;
      coef1_r  <= COEF_W'(256);
      coef2_r  <= '0;
      divr_r   <= DIVR_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        CFG_COEF0:  coef0_r  <= cfg_data;
        CFG_COEF1:  coef1_r  <= cfg_data;
        CFG_COEF2:  coef2_r  <= cfg_data;
        CFG_DIVR:   divr_r   <= cfg_data[DIVR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [EWX-1:0] w_cfg, w_eff;
  logic [EHX-1:0] h_cfg, h_eff;
  assign w_cfg = EWX'(width_r);
  assign h_cfg = EHX'(height_r);
  assign w_eff = (w_cfg < EWX'(MIN_SIZE)) ? EWX'(MIN_SIZE) :
                 (w_cfg > EWX'(MAX_WIDTH)) ? EWX'(MAX_WIDTH) : w_cfg;
  assign h_eff = (h_cfg < EHX'(MIN_SIZE)) ? EHX'(MIN_SIZE) :
                 (h_cfg > EHX'(MAX_HEIGHT)) ? EHX'(MAX_HEIGHT) : h_cfg;

  // position counters
  logic [CW-1:0]  col_r, c0;
  logic [RW-1:0]  row_r, r0;
  logic [EWX-1:0] c_inc;
  logic [EHX-1:0] r_inc;
  assign c0    = in_frame_start ? '0 : col_r;
  assign r0    = in_frame_start ? '0 : row_r;
  assign c_inc = EWX'(c0) + EWX'(1);
  assign r_inc = EHX'(r0) + EHX'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.capture) begin
      if (c_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
      end else begin
        col_r <= c_inc[CW-1:0];
      end
    end
  end

  logic [PCW-1:0] cc;
  logic [PRW-1:0] cr;
  assign cc = PCW'(c0) - PCW'(1);
  assign cr = PRW'(r0) - PRW'(1);

  logic [RGB_W-1:0] pix_r;
  logic [CW-1:0]    addr_r;
  logic             prod_r;
  logic             last_r;
  logic [POS_W-1:0] orow_r, ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= 1'b0;
    end else if (cmd.capture) begin
      prod_r <= (EHX'(r0) >= EHX'(2)) && (EWX'(c0) >= EWX'(2)) &&
                (EHX'(r0) < h_eff) && (EWX'(c0) < w_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r  <= in_pix;
      addr_r <= c0;
      last_r <= (EHX'(r0) == h_eff - EHX'(1)) && (EWX'(c0) == w_eff - EWX'(1));
      orow_r <= cr[POS_W-1:0];
      ocol_r <= cc[POS_W-1:0];
    end
  end

  assign sts.produce = prod_r;

  // line stores
  logic [RGB_W-1:0] older_rd, newer_rd;

  c3dc_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (addr_r),
    .wdata (newer_rd),
    .raddr (c0),
    .rdata (older_rd)
  );

  c3dc_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (addr_r),
    .wdata (pix_r),
    .raddr (c0),
    .rdata (newer_rd)
  );

  // 3x3 window, index = row * 3 + column
  logic [RGB_W-1:0] win_r [TAPS];

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= older_rd;
      win_r[5] <= newer_rd;
      win_r[8] <= pix_r;
    end
  end

  logic signed [PIX_W-1:0] coef [TAPS];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef[k]   = coef0_r[k*PIX_W +: PIX_W];
      coef[k+3] = coef1_r[k*PIX_W +: PIX_W];
      coef[k+6] = coef2_r[k*PIX_W +: PIX_W];
    end
  end

  logic signed [PIX_W-1:0] cur_coef;
  logic [RGB_W-1:0]        cur_pix;
  assign cur_coef = coef[cmd.tap];
  assign cur_pix  = win_r[cmd.tap];

  logic              divr_neg;
  logic [DIVR_W-1:0] den;
  assign divr_neg = divr_r[DIVR_W-1];
  assign den      = divr_neg ? (~divr_r + DIVR_W'(1)) : divr_r;

  logic [PIX_W-1:0] res [PLANES];

  for (genvar p = 0; p < PLANES; p++) begin : g_lane
    logic signed [SUM_W-1:0]  acc_r;
    logic signed [2*PIX_W:0]  prod;
    logic [SUM_W-1:0]         mag;
    logic [QUO_W-1:0]         num_r;
    logic [REM_W-1:0]         rem_r;
    logic                     flip_r;
    logic [REM_W:0]           rem_sh;
    logic                     ge;

    assign prod   = cur_coef * $signed({1'b0, cur_pix[p*PIX_W +: PIX_W]});
    assign mag    = acc_r[SUM_W-1] ? (~acc_r + SUM_W'(1)) : acc_r;
    assign rem_sh = {rem_r, num_r[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (cmd.mac_clr) begin
        acc_r <= '0;
      end else if (cmd.mac_en) begin
        acc_r <= acc_r + SUM_W'(prod);
      end
      if (cmd.div_init) begin
        num_r  <= mag[QUO_W-1:0];
        rem_r  <= '0;
        flip_r <= acc_r[SUM_W-1] ^ divr_neg;
      end else if (cmd.div_en) begin
        rem_r <= ge ? REM_W'(rem_sh - {1'b0, den}) : rem_sh[REM_W-1:0];
        num_r <= {num_r[QUO_W-2:0], ge};
      end
    end

    assign res[p] = flip_r ? '0 :
                    (num_r > QUO_W'(CLAMP_MAX)) ? PIX_W'(CLAMP_MAX) : num_r[PIX_W-1:0];
  end

  // output register
  logic             ovalid_r;
  logic [OUT_W-1:0] odata_r;
  logic             olast_r, ouser_r;
  logic             dz;
  assign dz = (divr_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= OUT_W'({ocol_r, orow_r,
                         dz ? '0 : res[2], dz ? '0 : res[1], dz ? '0 : res[0]});
      olast_r <= last_r;
      ouser_r <= dz;
    end
  end

  assign sts.out_busy = ovalid_r && !out_tready;
  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;
  assign out_tlast    = olast_r;
  assign out_tuser    = ouser_r;

endmodule

@@ rtl/c3dc_checker.sv @@
// ----------------------------------------------------------------------------
// c3dc_checker
// port level checks of the convolution block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c3dc_checker
  import c3dc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  `ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `ASSERT_RST(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `ASSERT_RST(a_dz_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[23:0] == 24'd0)
  `ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_tvalid)

endmodule

bind conv3x3_divide_clamp c3dc_checker u_c3dc_checker (.*);
